### src/dvll_pkg.sv
package dvll_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int TOTAL_WIDTH  = 48;

	typedef struct packed {
		logic [SAMPLE_WIDTH-1:0] sample_value;
		logic                    start_of_series;
		logic                    end_of_series;
	} in_item_t;

	typedef struct packed {
		logic [TOTAL_WIDTH-1:0] likelihood_total;
		logic                   overflow_flag;
	} out_item_t;

	typedef enum logic [1:0] {
		REG_OMEGA = 2'd0,
		REG_PHI   = 2'd1,
		REG_KAPPA = 2'd2
	} reg_idx_t;

	localparam logic signed [15:0] PHI_RESET   = 16'sd14746;
	localparam logic signed [15:0] KAPPA_RESET = 16'sd1638;
	localparam logic signed [33:0] LOG2E_Q30   = 34'sd1549082005;
	localparam logic signed [23:0] EXP_ARG_LIM = 24'sd4194304;

	// Taylor coefficients of 2^f in Q.30, highest order first at index 5.
	function automatic logic [31:0] exp2_coef(input logic [2:0] i);
		case (i)
			3'd0: exp2_coef = 32'd1073741824;
			3'd1: exp2_coef = 32'd744261118;
			3'd2: exp2_coef = 32'd257941248;
			3'd3: exp2_coef = 32'd59597083;
			3'd4: exp2_coef = 32'd10327387;
			default: exp2_coef = 32'd1431680;
		endcase
	endfunction

endpackage

### src/dcs_volatility_log_likelihood.sv
// Score-driven log-volatility Gaussian likelihood accumulator.
// Return samples enter on the input channel (in_valid / in_stall) as a
// packed struct holding the sample and its start and end marks. A start
// transfer resets the recursion and the total. Every other transfer runs
// the recursion: it forms last r^2*exp(-2*lambda), the score, the new
// filter state and lambda, and then r^2*exp(-2*lambda) for the current
// sample, adding half of it plus lambda to a saturating running total.
// A transfer with the end mark produces one result transfer on the output
// channel (out_valid / out_stall) with the total and the saturation flag.
// All products but the sample square share one registered 34x34 multiplier
// under a sequencer. A non-start item passes through two exponentials
// (argument multiply, five Horner steps, two wide partial products), the
// recursion states S_ST1 to S_ST3, the total update and the result state;
// a start item goes straight to the result state. The input is stalled
// while an item is in work, so the next transfer is taken once the block
// is idle again. The result is registered and holds its payload while
// stalled; a finished item waits in its last state only while an earlier
// result is still undelivered.
// Asynchronous reset clears the recursion state, the total and the flag and
// loads the register defaults. Configuration writes are always accepted.
module dcs_volatility_log_likelihood (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  dvll_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output dvll_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_wdata
);
	localparam logic signed [63:0] TMAX =
		64'sd0 + ((64'sd1 <<< (dvll_pkg::TOTAL_WIDTH - 1)) - 64'sd1);
	localparam logic signed [63:0] TMIN = -TMAX - 64'sd1;

	typedef enum logic [3:0] {
		S_IDLE, S_EXPX, S_EXPY, S_HORN, S_HWAIT, S_SC0, S_SC1, S_SC2,
		S_ST1, S_ST2, S_ST3, S_TOT, S_OUT
	} state_t;

	state_t state_q;
	logic signed [15:0] omega_q, phi_q, kappa_q;
	logic signed [31:0] fstate_q, lastlam_q, lam_q;
	logic signed [dvll_pkg::SAMPLE_WIDTH-1:0] lastr_q, r_q;
	logic signed [63:0] total_q;
	logic sat_q, ov_q, pass_q, end_q;
	logic signed [63:0] acc_q;
	logic [2:0] hidx_q;
	logic [31:0] p_q;
	logic [63:0] r2_q;
	logic signed [31:0] k_q;
	logic [15:0] f_q;
	logic signed [67:0] prod;
	logic signed [33:0] ma, mb;
	logic [127:0] wide_q;
	logic [dvll_pkg::TOTAL_WIDTH-1:0] res_tot_q;
	logic res_ov_q;

	dvll_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(prod));

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign out_data.likelihood_total = res_tot_q;
	assign out_data.overflow_flag = res_ov_q;

	// Current exponential operands.
	logic signed [31:0] cur_lam;
	logic signed [dvll_pkg::SAMPLE_WIDTH-1:0] cur_r;
	logic signed [33:0] xcl;
	logic signed [34:0] xraw;
	logic [dvll_pkg::SAMPLE_WIDTH-1:0] rmag;
	assign cur_lam = pass_q ? lam_q : lastlam_q;
	assign cur_r = pass_q ? r_q : lastr_q;
	assign xraw = -35'sd2 * 35'(cur_lam);
	assign xcl = (xraw > 35'(dvll_pkg::EXP_ARG_LIM)) ? 34'(dvll_pkg::EXP_ARG_LIM) :
		(xraw < -35'(dvll_pkg::EXP_ARG_LIM)) ? -34'(dvll_pkg::EXP_ARG_LIM) : 34'(xraw);
	assign rmag = cur_r[dvll_pkg::SAMPLE_WIDTH-1] ? -cur_r : cur_r;

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_EXPX: begin ma = xcl; mb = dvll_pkg::LOG2E_Q30; end
			S_HORN: begin ma = {2'b0, p_q}; mb = {4'b0, f_q, 14'b0}; end
			S_SC0: begin ma = {2'b0, r2_q[31:0]}; mb = {2'b0, p_q}; end
			S_SC1: begin ma = {2'b0, r2_q[63:32]}; mb = {2'b0, p_q}; end
			S_ST1: begin ma = 34'(phi_q); mb = 34'(fstate_q); end
			S_ST2: begin ma = 34'(kappa_q); mb = 34'(acc_q); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// Scaling of the wide product by 2^(k-30), saturated to the total range.
	logic [63:0] scaled;
	logic scaled_ov;
	logic signed [31:0] sh;
	always_comb begin
		logic [127:0] t;
		sh = k_q - 32'sd30;
		scaled = '0;
		scaled_ov = 1'b0;
		t = '0;
		if (wide_q == '0) begin
			scaled = '0;
		end else if (sh >= 0) begin
			if (sh >= 64 || wide_q[127:64] != '0 ||
				wide_q[63:0] > (64'(TMAX) >> sh[5:0])) begin
				scaled_ov = 1'b1;
				scaled = 64'(TMAX);
			end else begin
				scaled = wide_q[63:0] << sh[5:0];
			end
		end else begin
			if (-sh >= 128) begin
				t = '0;
			end else begin
				t = wide_q >> 7'(-sh);
			end
			if (t > 128'(TMAX)) begin
				scaled_ov = 1'b1;
				scaled = 64'(TMAX);
			end else begin
				scaled = t[63:0];
			end
		end
	end

	// New filter state and lambda, each clamped to the signed 32-bit range.
	logic signed [63:0] st_sum, lam_sum, score_v, tadd1;
	logic signed [31:0] st_cl, lam_cl;
	logic st_ov, lam_ov;
	always_comb begin
		st_sum = (acc_q >>> 14) + 64'(prod >>> 14);
		st_ov = 1'b1;
		if (st_sum > 64'sd2147483647) begin
			st_cl = 32'sh7fffffff;
		end else if (st_sum < -64'sd2147483648) begin
			st_cl = 32'sh80000000;
		end else begin
			st_cl = 32'(st_sum);
			st_ov = 1'b0;
		end
		lam_sum = 64'(omega_q) * 64'sd4 + 64'(st_cl);
		lam_ov = 1'b1;
		if (lam_sum > 64'sd2147483647) begin
			lam_cl = 32'sh7fffffff;
		end else if (lam_sum < -64'sd2147483648) begin
			lam_cl = 32'sh80000000;
		end else begin
			lam_cl = 32'(lam_sum);
			lam_ov = 1'b0;
		end
		score_v = 64'(scaled) - 64'sd65536;
		tadd1 = total_q + 64'(scaled >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			omega_q <= '0;
			phi_q <= dvll_pkg::PHI_RESET;
			kappa_q <= dvll_pkg::KAPPA_RESET;
			fstate_q <= '0;
			lastlam_q <= '0;
			lam_q <= '0;
			lastr_q <= '0;
			total_q <= '0;
			sat_q <= 1'b0;
			out_valid <= 1'b0;
			ov_q <= 1'b0;
			pass_q <= 1'b0;
			end_q <= 1'b0;
			res_tot_q <= '0;
			res_ov_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					dvll_pkg::REG_OMEGA: omega_q <= cfg_wdata;
					dvll_pkg::REG_PHI:   phi_q <= cfg_wdata;
					dvll_pkg::REG_KAPPA: kappa_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						r_q <= in_data.sample_value;
						end_q <= in_data.end_of_series;
						ov_q <= 1'b0;
						pass_q <= 1'b0;
						if (in_data.start_of_series) begin
							fstate_q <= '0;
							lastlam_q <= 32'(64'(omega_q) * 64'sd4);
							total_q <= '0;
							sat_q <= 1'b0;
							lastr_q <= in_data.sample_value;
							state_q <= S_OUT;
						end else begin
							state_q <= S_EXPX;
						end
					end
				end
				S_EXPX: begin
					r2_q <= 64'(rmag) * 64'(rmag);
					state_q <= S_EXPY;
				end
				S_EXPY: begin
					k_q <= 32'(prod >>> 46);
					f_q <= prod[45:30];
					p_q <= dvll_pkg::exp2_coef(3'd5);
					hidx_q <= 3'd4;
					state_q <= S_HORN;
				end
				// A Horner multiply issues in S_HORN and its product is
				// folded into p_q in S_HWAIT.
				S_HORN: state_q <= S_HWAIT;
				S_HWAIT: begin
					p_q <= dvll_pkg::exp2_coef(hidx_q) + 32'(prod >>> 30);
					hidx_q <= hidx_q - 3'd1;
					state_q <= (hidx_q == 3'd0) ? S_SC0 : S_HORN;
				end
				S_SC0: state_q <= S_SC1;
				S_SC1: begin
					wide_q <= {64'b0, 64'(prod)};
					state_q <= S_SC2;
				end
				S_SC2: begin
					wide_q <= wide_q + {32'b0, 64'(prod), 32'b0};
					state_q <= pass_q ? S_TOT : S_ST1;
				end
				S_ST1: begin
					if (scaled_ov) ov_q <= 1'b1;
					if (score_v > 64'sd2147483647) begin
						acc_q <= 64'sd2147483647;
						ov_q <= 1'b1;
					end else begin
						acc_q <= score_v;
					end
					state_q <= S_ST2;
				end
				S_ST2: begin
					acc_q <= 64'(prod);
					state_q <= S_ST3;
				end
				S_ST3: begin
					state_q <= S_EXPX;
					pass_q <= 1'b1;
					fstate_q <= st_cl;
					lam_q <= lam_cl;
					if (st_ov || lam_ov) ov_q <= 1'b1;
				end
				S_TOT: begin
					logic ovn;
					logic signed [63:0] t1, t2;
					ovn = ov_q | scaled_ov;
					t1 = tadd1;
					if (t1 > TMAX) begin t1 = TMAX; ovn = 1'b1; end
					t2 = t1 + 64'(lam_q);
					if (t2 > TMAX) begin t2 = TMAX; ovn = 1'b1; end
					else if (t2 < TMIN) begin t2 = TMIN; ovn = 1'b1; end
					total_q <= t2;
					lastlam_q <= lam_q;
					lastr_q <= r_q;
					if (ovn) sat_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					// An end item waits here until the result register is free.
					if (!end_q) begin
						state_q <= S_IDLE;
					end else if (!out_valid) begin
						res_tot_q <= total_q[dvll_pkg::TOTAL_WIDTH-1:0];
						res_ov_q <= sat_q;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### src/dvll_mul.sv
// Shared signed 34x34 multiplier with a registered product.
module dvll_mul (
	input  logic               clk,
	input  logic signed [33:0] a,
	input  logic signed [33:0] b,
	output logic signed [67:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule
